@@ sv/csvfs_pkg.sv @@
`default_nettype none

package csvfs_pkg;

  // Input item: one character or the end-of-input mark.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } char_item_t;

  // Result item.
  typedef struct packed {
    logic [1:0] status;
    logic [1:0] append_count;
    logic [7:0] append_first;
    logic [7:0] append_second;
    logic [7:0] field_length;
    logic       field_truncated;
  } result_t;

  // Classified character as handed from the front to the back.
  typedef struct packed {
    logic [7:0] ch;
    logic       is_eof;
    logic       is_delim;
    logic       is_quote;
    logic       is_newline;
  } cls_item_t;

  // Configuration as seen by the front and the back.
  typedef struct packed {
    logic [7:0] delimiter_char;
    logic [7:0] quote_char;
    logic       lenient_mode;
  } cfg_t;

  typedef enum logic [2:0] {
    PH_SKIP  = 3'b001,
    PH_READY = 3'b010,
    PH_DQ    = 3'b100
  } phase_t;

  localparam logic [1:0] ST_INCOMPLETE = 2'd0;
  localparam logic [1:0] ST_FIELD      = 2'd1;
  localparam logic [1:0] ST_ROW        = 2'd2;
  localparam logic [1:0] ST_ERROR      = 2'd3;

  localparam logic [1:0] CFG_DELIMITER = 2'd0;
  localparam logic [1:0] CFG_QUOTE     = 2'd1;
  localparam logic [1:0] CFG_LENIENT   = 2'd2;

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_DQUOTE = 8'h22;

endpackage

`default_nettype wire

@@ sv/csvfs_fifo.sv @@
`default_nettype none

module csvfs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

@@ sv/csvfs_front.sv @@
`default_nettype none

module csvfs_front
  import csvfs_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       push,
  input  wire char_item_t char_item,
  output logic            full,
  input  wire logic       cls_pop,
  output cls_item_t       cls_item,
  output logic            cls_empty
);

  cls_item_t cls_in;

  // A NUL byte is end of input, but it can still match the delimiter or
  // the quote when those are set to zero. The end mark matches nothing.
  always_comb begin
    cls_in.ch         = char_item.end_of_input ? CHAR_NUL : char_item.in_byte;
    cls_in.is_eof     = char_item.end_of_input || (char_item.in_byte == CHAR_NUL);
    cls_in.is_delim   = !char_item.end_of_input && (char_item.in_byte == cfg.delimiter_char);
    cls_in.is_quote   = !char_item.end_of_input && (char_item.in_byte == cfg.quote_char);
    cls_in.is_newline = !char_item.end_of_input &&
                        (char_item.in_byte inside {CHAR_LF, CHAR_CR});
  end

  csvfs_fifo #(
    .WIDTH($bits(cls_item_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_cls_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(cls_in),
    .full (full),
    .pop  (cls_pop),
    .rdata(cls_item),
    .empty(cls_empty)
  );

endmodule

`default_nettype wire

@@ sv/csvfs_back.sv @@
`default_nettype none

module csvfs_back
  import csvfs_pkg::*;
#(
  parameter int FIELD_BUF_BYTES = 256,
  parameter int QUEUE_DEPTH     = 2
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cfg_t      cfg,
  input  wire cls_item_t cls_item,
  input  wire logic      cls_empty,
  output logic           cls_pop,
  output result_t        result,
  output logic           empty,
  input  wire logic      pop
);

  localparam int CNTW = $clog2(FIELD_BUF_BYTES);
  localparam logic [CNTW-1:0] CAP = CNTW'(FIELD_BUF_BYTES - 1);

  phase_t          parse_phase;
  logic            in_quotes;
  logic [CNTW-1:0] field_count;
  logic            overflow_seen;

  phase_t          parse_phase_next;
  logic            in_quotes_next;
  logic [CNTW-1:0] field_count_next;
  logic            overflow_seen_next;

  result_t res;
  logic    out_full;
  logic    step;

  assign step    = !cls_empty && !out_full;
  assign cls_pop = step;

  always_comb begin
    phase_t          ph;
    logic            q;
    logic [CNTW-1:0] n;
    logic            ov;
    logic            done;
    logic            err;
    logic            fin;
    logic            s1;
    logic            s2;
    logic [7:0]      b1;
    logic [7:0]      b2;
    logic [1:0]      st;
    logic [1:0]      ac;
    logic [7:0]      a0;
    logic [7:0]      a1;

    ph   = parse_phase;
    q    = in_quotes;
    n    = field_count;
    ov   = overflow_seen;
    done = 1'b0;
    err  = 1'b0;
    fin  = 1'b0;
    s1   = 1'b0;
    s2   = 1'b0;
    b1   = cls_item.ch;
    b2   = cls_item.ch;
    st   = ST_INCOMPLETE;
    ac   = 2'd0;
    a0   = 8'd0;
    a1   = 8'd0;

    if (ph == PH_SKIP) begin
      if (cls_item.is_eof || cls_item.is_newline) begin
        done = 1'b1;
      end else begin
        ph = PH_READY;
      end
    end

    // A quote was seen inside quotes: it closes the quotes, or when doubled stands
    // for one quote byte; another byte after it is kept with the quote if lenient, else an error.
    if (!done && ph == PH_DQ) begin
      if (cls_item.is_delim || cls_item.is_newline || cls_item.is_eof) begin
        q  = 1'b0;
        ph = PH_READY;
      end else if (cls_item.is_quote) begin
        s1   = 1'b1;
        ph   = PH_READY;
        done = 1'b1;
      end else if (cfg.lenient_mode) begin
        s1   = 1'b1;
        b1   = cfg.quote_char;
        s2   = 1'b1;
        ph   = PH_READY;
        done = 1'b1;
      end else begin
        err  = 1'b1;
        done = 1'b1;
      end
    end

    if (!done && cls_item.is_quote) begin
      if (q) begin
        ph   = PH_DQ;
        done = 1'b1;
      end else if (n == '0) begin
        q    = 1'b1;
        done = 1'b1;
      end else if (!cfg.lenient_mode) begin
        err  = 1'b1;
        done = 1'b1;
      end
    end

    if (!done) begin
      if (q && cls_item.is_eof) begin
        if (!cfg.lenient_mode) begin
          err = 1'b1;
        end else begin
          q   = 1'b0;
          st  = ST_ROW;
          fin = 1'b1;
        end
      end else if (!q && cls_item.is_delim) begin
        st  = ST_FIELD;
        fin = 1'b1;
      end else if (!q && (cls_item.is_newline || cls_item.is_eof)) begin
        st  = ST_ROW;
        fin = 1'b1;
      end else begin
        s1 = 1'b1;
      end
    end

    // Bytes beyond the field's capacity are dropped and remembered.
    if (s1) begin
      if (n == CAP) begin
        ov = 1'b1;
      end else begin
        n  = n + 1'b1;
        a0 = b1;
        ac = 2'd1;
      end
    end
    if (s2) begin
      if (n == CAP) begin
        ov = 1'b1;
      end else begin
        n = n + 1'b1;
        if (ac == 2'd0) begin
          a0 = b2;
        end else begin
          a1 = b2;
        end
        ac = ac + 2'd1;
      end
    end

    res.status          = st;
    res.append_count    = ac;
    res.append_first    = a0;
    res.append_second   = a1;
    res.field_length    = 8'd0;
    res.field_truncated = 1'b0;

    if (fin) begin
      res.field_length    = 8'(n);
      res.field_truncated = ov;
      n  = '0;
      ov = 1'b0;
      if (st == ST_ROW) begin
        ph = PH_SKIP;
      end
    end

    // A parse error reports only the status and leaves the state alone.
    if (err) begin
      res                = '0;
      res.status         = ST_ERROR;
      parse_phase_next   = parse_phase;
      in_quotes_next     = in_quotes;
      field_count_next   = field_count;
      overflow_seen_next = overflow_seen;
    end else begin
      parse_phase_next   = ph;
      in_quotes_next     = q;
      field_count_next   = n;
      overflow_seen_next = ov;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase   <= PH_SKIP;
      in_quotes     <= 1'b0;
      field_count   <= '0;
      overflow_seen <= 1'b0;
    end else if (step) begin
      parse_phase   <= parse_phase_next;
      in_quotes     <= in_quotes_next;
      field_count   <= field_count_next;
      overflow_seen <= overflow_seen_next;
    end
  end

  csvfs_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_out_queue (
    .clk  (clk),
    .rst  (rst),
    .push (step),
    .wdata(res),
    .full (out_full),
    .pop  (pop),
    .rdata(result),
    .empty(empty)
  );

endmodule

`default_nettype wire

@@ sv/csv_field_splitter_top.sv @@
// CSV field splitter: one text character per item in, one result per item out.
// Input side is a queue: present char_item and raise push while full is low.
// Each item carries a byte and an end-of-input flag; a NUL byte also ends input.
// Result side is a queue: while empty is low, result holds the oldest result,
// and raising pop takes it. Each result gives a status (incomplete, field
// complete, end of row, parse error), the bytes appended to the current field
// and, when a field completes, its length and a truncation flag.
// Configuration registers (delimiter, quote, lenient mode) are written through
// cfg_valid/cfg_index/cfg_data; cfg_ready is always high. Write them only while
// no items are in flight.
// An accepted item is written into the queue between front and back; the parse
// step then writes its result into the output queue, which drives the result port.
// Throughput is one item per cycle while the output queue is not full, set by the parse step in the
// back end, which holds the phase, quote flag and field byte count.
// Reset restores the default comma and double quote, strict mode, and the
// skip-blank-lines phase, and empties both queues.
// When the receiver stops popping, the output queue fills, the parse step
// halts, the queue between front and back fills, and full rises.
`default_nettype none

module csv_field_splitter_top
  import csvfs_pkg::*;
#(
  parameter int FIELD_BUF_BYTES = 256,
  parameter int QUEUE_DEPTH     = 2
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire char_item_t char_item,
  output logic            empty,
  input  wire logic       pop,
  output result_t         result,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  cfg_t      cfg;
  cls_item_t cls_item;
  logic      cls_empty;
  logic      cls_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delimiter_char <= CHAR_COMMA;
      cfg.quote_char     <= CHAR_DQUOTE;
      cfg.lenient_mode   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DELIMITER: cfg.delimiter_char <= cfg_data;
        CFG_QUOTE:     cfg.quote_char     <= cfg_data;
        CFG_LENIENT:   cfg.lenient_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  csvfs_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .push     (push),
    .char_item(char_item),
    .full     (full),
    .cls_pop  (cls_pop),
    .cls_item (cls_item),
    .cls_empty(cls_empty)
  );

  csvfs_back #(
    .FIELD_BUF_BYTES(FIELD_BUF_BYTES),
    .QUEUE_DEPTH    (QUEUE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cls_item (cls_item),
    .cls_empty(cls_empty),
    .cls_pop  (cls_pop),
    .result   (result),
    .empty    (empty),
    .pop      (pop)
  );

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import csvfs_pkg::*;

  localparam int FIELD_BYTES   = 256;
  localparam int ITEMS_PER_SET = 250;
  localparam int STALL_LIMIT   = 1000;

  // Tracks the parser state and the result that each accepted character must produce.
  class field_scoreboard;
    logic [7:0] delim;
    logic [7:0] quote;
    bit         lenient;
    phase_t     phase;
    bit         quoted;
    int         kept;
    bit         dropped;
    result_t    split_results_q[$];
    int         errors;
    // Working copy of the step being worked out.
    result_t    step_res;
    int         step_kept;
    bit         step_dropped;

    function new();
      delim   = CHAR_COMMA;
      quote   = CHAR_DQUOTE;
      lenient = 1'b0;
      phase   = PH_SKIP;
      quoted  = 1'b0;
      kept    = 0;
      dropped = 1'b0;
      errors  = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        CFG_DELIMITER: begin
          delim = val;
        end
        CFG_QUOTE: begin
          quote = val;
        end
        CFG_LENIENT: begin
          lenient = val[0];
        end
        default: begin
        end
      endcase
    endfunction

    function int pending();
      return split_results_q.size();
    endfunction

    // A byte beyond the field capacity is dropped and only remembered as overflow.
    function void keep_byte(logic [7:0] b);
      if (step_kept >= FIELD_BYTES - 1) begin
        step_dropped = 1'b1;
        return;
      end
      step_kept++;
      if (step_res.append_count == 2'd0) step_res.append_first = b;
      else step_res.append_second = b;
      step_res.append_count = step_res.append_count + 2'd1;
    endfunction

    function void split_char(char_item_t it);
      logic [7:0] c;
      bit         eof, is_del, is_q, nl, done, err;
      phase_t     ph;
      bit         q;
      step_res     = '0;
      step_kept    = kept;
      step_dropped = dropped;
      ph   = phase;
      q    = quoted;
      done = 1'b0;
      err  = 1'b0;
      c      = it.end_of_input ? CHAR_NUL : it.in_byte;
      eof    = it.end_of_input || c == CHAR_NUL;
      is_del = !it.end_of_input && c == delim;
      is_q   = !it.end_of_input && c == quote;
      nl     = !it.end_of_input && (c == CHAR_LF || c == CHAR_CR);

      if (ph == PH_SKIP) begin
        if (eof || nl) done = 1'b1;
        else ph = PH_READY;
      end
      if (!done && ph == PH_DQ) begin
        if (is_del || nl || eof) begin
          q  = 1'b0;
          ph = PH_READY;
        end else if (is_q) begin
          keep_byte(c);
          ph   = PH_READY;
          done = 1'b1;
        end else if (lenient) begin
          keep_byte(quote);
          keep_byte(c);
          ph   = PH_READY;
          done = 1'b1;
        end else begin
          err = 1'b1;
        end
      end
      if (!done && !err && is_q) begin
        if (q) begin
          ph   = PH_DQ;
          done = 1'b1;
        end else if (step_kept == 0) begin
          q    = 1'b1;
          done = 1'b1;
        end else if (!lenient) begin
          err = 1'b1;
        end
      end
      if (!done && !err) begin
        if (q && eof) begin
          if (!lenient) err = 1'b1;
          q = 1'b0;
          step_res.status = ST_ROW;
        end else if (!q && is_del) begin
          step_res.status = ST_FIELD;
        end else if (!q && (nl || eof)) begin
          step_res.status = ST_ROW;
        end else begin
          keep_byte(c);
          done = 1'b1;
        end
        if (!done && !err) begin
          step_res.field_length    = 8'(step_kept);
          step_res.field_truncated = step_dropped;
          step_kept    = 0;
          step_dropped = 1'b0;
          if (step_res.status == ST_ROW) ph = PH_SKIP;
        end
      end

      // A parse error reports nothing else and leaves the state alone.
      if (err) begin
        step_res        = '0;
        step_res.status = ST_ERROR;
      end else begin
        phase   = ph;
        quoted  = q;
        kept    = step_kept;
        dropped = step_dropped;
      end
      split_results_q.push_back(step_res);
    endfunction

    task report(string msg);
      $display("%0t ns: %s", $time, msg);
      errors++;
    endtask

    task cmp(string name, int got_v, int want_v);
      if (got_v != want_v) report($sformatf("%s is %0d, expected %0d", name, got_v, want_v));
    endtask

    task check_result(result_t got);
      result_t want;
      if (split_results_q.size() == 0) begin
        report($sformatf("result with status %0d arrived with none outstanding", got.status));
        return;
      end
      want = split_results_q.pop_front();
      cmp("status", got.status, want.status);
      cmp("append_count", got.append_count, want.append_count);
      cmp("append_first", got.append_first, want.append_first);
      cmp("append_second", got.append_second, want.append_second);
      cmp("field_length", got.field_length, want.field_length);
      cmp("field_truncated", got.field_truncated, want.field_truncated);
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  char_item_t char_item = '0;
  logic       empty;
  logic       pop = 1'b0;
  result_t    result;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = CFG_DELIMITER;
  logic [7:0] cfg_data = '0;

  field_scoreboard splitter_sb;
  char_item_t      text_q[$];
  logic [7:0]      cur_delim = CHAR_COMMA;
  logic [7:0]      cur_quote = CHAR_DQUOTE;
  bit              steady = 1'b0;
  int              idle_cycles = 0;

  csv_field_splitter_top #(
    .FIELD_BUF_BYTES(FIELD_BYTES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .char_item(char_item),
    .empty(empty),
    .pop(pop),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) splitter_sb.check_result(result);
      pop <= steady || ($urandom_range(99) >= 16);
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic add_char(logic [7:0] c);
    char_item_t it;
    it.in_byte      = c;
    it.end_of_input = 1'b0;
    text_q.push_back(it);
  endtask

  // The byte that rides along with an end mark must be ignored by the parser.
  task automatic add_end(logic [7:0] junk);
    char_item_t it;
    it.in_byte      = junk;
    it.end_of_input = 1'b1;
    text_q.push_back(it);
  endtask

  task automatic add_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    c = CHAR_NUL;
    while (c == CHAR_NUL || c == CHAR_LF || c == CHAR_CR || c == cur_delim || c == cur_quote)
      c = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(32, 126));
    return c;
  endfunction

  task automatic add_field(bit is_quoted, int len);
    int i, pick;
    if (is_quoted) add_char(cur_quote);
    for (i = 0; i < len; i++) begin
      pick = $urandom_range(19);
      if (is_quoted && pick == 0) begin
        add_char(cur_delim);
      end else if (is_quoted && pick == 1) begin
        add_char(cur_quote);
        add_char(cur_quote);
      end else if (is_quoted && pick == 2) begin
        add_char(CHAR_LF);
      end else begin
        add_char(plain_char());
      end
    end
    if (is_quoted) add_char(cur_quote);
  endtask

  task automatic end_row();
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) begin
      add_char(CHAR_LF);
    end else if (pick < 75) begin
      add_char(CHAR_CR);
      add_char(CHAR_LF);
    end else if (pick < 85) begin
      add_char(CHAR_CR);
    end else if (pick < 93) begin
      add_end(8'($urandom_range(255)));
    end else begin
      add_char(CHAR_NUL);
    end
  endtask

  task automatic add_row();
    int pick, nf, i, len;
    pick = $urandom_range(99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(3) == 0) add_end(8'($urandom_range(255)));
        else add_char(8'($urandom_range(255)));
      end
    end else if (pick < 12) begin
      // Quote left open at end of input.
      add_char(cur_quote);
      add_char(plain_char());
      if ($urandom_range(1) == 0) add_end(8'($urandom_range(255)));
      else add_char(CHAR_NUL);
    end else if (pick < 16) begin
      // Quote in the middle of an unquoted field.
      add_char(plain_char());
      add_char(cur_quote);
      add_char(plain_char());
      add_char(cur_delim);
      end_row();
    end else if (pick < 20) begin
      // Stray byte right after a closing quote.
      add_char(cur_quote);
      add_char(plain_char());
      add_char(cur_quote);
      add_char(plain_char());
      end_row();
    end else begin
      if (pick < 26) begin
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(3))
            0: add_char(CHAR_LF);
            1: add_char(CHAR_CR);
            2: add_char(CHAR_NUL);
            default: add_end(8'($urandom_range(255)));
          endcase
        end
      end
      nf = $urandom_range(1, 5);
      for (i = 0; i < nf; i++) begin
        if (i > 0) add_char(cur_delim);
        len = ($urandom_range(99) < 2) ? $urandom_range(250, 300) : $urandom_range(0, 6);
        add_field($urandom_range(9) < 3, len);
      end
      end_row();
    end
  endtask

  task automatic send_text();
    int  k;
    bit  gap;
    k = 0;
    while (k < text_q.size()) begin
      gap = !steady && ($urandom_range(99) < 16);
      push      <= !gap;
      char_item <= text_q[k];
      @(posedge clk);
      if (push && !full) begin
        splitter_sb.split_char(char_item);
        k++;
      end
    end
    push <= 1'b0;
    text_q.delete();
  endtask

  task automatic wait_drained();
    while (splitter_sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Valid stays high across the three writes so it is never lowered and raised in one step.
  task automatic set_config(logic [7:0] d, logic [7:0] q, bit l);
    logic [1:0] idx [3];
    logic [7:0] val [3];
    int         i;
    idx = '{CFG_DELIMITER, CFG_QUOTE, CFG_LENIENT};
    val = '{d, q, {7'd0, l}};
    for (i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      splitter_sb.write_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
    cur_delim = d;
    cur_quote = q;
  endtask

  initial begin
    int i, p;
    splitter_sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (p = 0; p < 7; p++) begin
      if (p > 0) begin
        wait_drained();
        case (p)
          1: set_config(CHAR_COMMA, CHAR_DQUOTE, 1'b1);
          2: set_config(8'h00, 8'h00, 1'b0);
          3: set_config(8'hFF, 8'hFF, 1'b1);
          4: set_config(8'h09, 8'h27, 1'b0);
          5: set_config(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b1);
          default: set_config(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0);
        endcase
      end
      steady = (p == 3);

      if (p == 0) begin
        // Blank lines, a plain and a quoted field with doubled quotes, a stray quote,
        // an open quote at end of input, and a quote before bytes 255, LF and 255 left open at the end mark.
        add_char(CHAR_LF);
        add_char(CHAR_CR);
        add_end(8'hFF);
        add_char(CHAR_NUL);
        add_text("a,\"x,\"\"\"\n");
        add_text("b\"c\n");
        add_text("\"d");
        add_end(8'h00);
        add_char(cur_quote);
        add_char(8'hFF);
        add_char(CHAR_LF);
        add_char(8'hFF);
        add_end(8'h5A);
        // One byte past capacity.
        add_field(1'b0, FIELD_BYTES);
        end_row();
      end else if (p == 1) begin
        // The lenient pair after a closing quote lands on the capacity edge.
        add_char(cur_quote);
        for (i = 0; i < FIELD_BYTES - 2; i++) add_char(plain_char());
        add_char(cur_quote);
        add_char(plain_char());
        end_row();
      end

      while (text_q.size() < ITEMS_PER_SET) add_row();
      send_text();
    end

    wait_drained();
    if (splitter_sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
